/* design/pht_pkg.sv */
package pht_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int KEY_W    = 48;
    localparam int LEN_W    = 4;
    localparam int TIME_W   = 40;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = 5;
    localparam int GEN_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam int KEY_CHARS = 6;
    localparam logic [LEN_W-1:0]  KEY_LEN  = LEN_W'(KEY_CHARS);
    localparam logic [7:0]        CH_UPPER_A = 8'h41;
    localparam logic [7:0]        CH_UPPER_Z = 8'h5A;
    localparam logic [7:0]        CH_DIGIT_0 = 8'h30;
    localparam logic [7:0]        CH_DIGIT_9 = 8'h39;
    localparam logic [GEN_W-1:0]  GEN_MAX    = '1;
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DISABLED  = 3'd2,
        ST_BAD_KEY   = 3'd3,
        ST_BAD_TIME  = 3'd4,
        ST_GEN_FULL  = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED  = 2'd0,
        CFG_MIN_TIME = 2'd1,
        CFG_MAX_TIME = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_RECORD = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_COMP,
        S_OLD_READ,
        S_OLD_COMP,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

/* design/pht_if.sv */
interface pht_req_if import pht_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [KEY_W-1:0]  game_key;
    logic [LEN_W-1:0]  key_length;
    logic [TIME_W-1:0] play_time;

    modport source (output valid, command, game_key, key_length, play_time, input ready);
    modport sink   (input valid, command, game_key, key_length, play_time, output ready);
endinterface

interface pht_rsp_if import pht_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   found_time;
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  entry_count;
    logic [GEN_W-1:0]    generation_out;

    modport source (output valid, found_time, status, entry_count, generation_out,
                    input ready);
    modport sink   (input valid, found_time, status, entry_count, generation_out,
                    output ready);
endinterface

interface pht_cfg_if import pht_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/play_history_table.sv */
// channel | dir | payload                                          | accepted when
// cfg     | in  | index, data                                      | valid && ready
// req     | in  | command, game_key, key_length, play_time         | valid && ready
// rsp     | out | found_time, status, entry_count, generation_out  | valid && ready
//
// One item at a time. A rejected item goes straight to the done state; a scan
// reads one entry at a time through the single memory read port and compares it:
// a lookup stops at the first hit or after the last entry, a record adds the
// write, and a record into a full table with no match first searches all
// CAPACITY entries for the oldest one (lowest play time) to overwrite.
// Reset clears count, generation and config; the entry memories need no clearing.
// A pending result sits in the output register; the next item is taken meanwhile.
module play_history_table
    import pht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pht_cfg_if.sink   cfg,
    pht_req_if.sink   req,
    pht_rsp_if.source rsp
);

    logic [KEY_W-1:0]  key_mem  [CAPACITY];
    logic [TIME_W-1:0] time_mem [CAPACITY];

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [TIME_W-1:0]   best_reg, best_next;
    logic                append_reg, append_next;
    logic                cmd_reg, cmd_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [TIME_W-1:0]   found_reg, found_next;
    status_t             status_reg, status_next;
    logic [CNT_W-1:0]    fill_count_reg, fill_count_next;
    logic [GEN_W-1:0]    gen_reg, gen_next;

    logic                out_valid_reg;
    logic [TIME_W-1:0]   out_found_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ENTRY_W-1:0]  out_count_reg;
    logic [GEN_W-1:0]    out_gen_reg;

    logic                enabled_reg;
    logic [TIME_W-1:0]   min_time_reg;
    logic [TIME_W-1:0]   max_time_reg;

    logic [KEY_W-1:0]    rd_key_reg;
    logic [TIME_W-1:0]   rd_time_reg;

    logic                req_acc;
    logic                out_free;
    logic                mem_we;
    logic                pre_pass;
    status_t             pre_status;
    logic                key_hit;
    logic                scan_last;
    logic                table_full;

    function automatic logic key_ok(input logic [KEY_W-1:0] key,
                                    input logic [LEN_W-1:0] len);
        logic       ok;
        logic [7:0] ch;
        ok = (len == KEY_LEN);
        for (int n = 0; n < KEY_CHARS; n++) begin
            ch = key[8*n +: 8];
            if (!((ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ||
                  (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)))
                ok = 1'b0;
        end
        return ok;
    endfunction

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b0;
            min_time_reg <= '0;
            max_time_reg <= TIME_MAX;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_ENABLED:  enabled_reg  <= cfg.data[0];
                CFG_MIN_TIME: min_time_reg <= cfg.data[TIME_W-1:0];
                CFG_MAX_TIME: max_time_reg <= cfg.data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // entry memories
    always_ff @(posedge clk)
    begin
        rd_key_reg  <= key_mem[idx_reg];
        rd_time_reg <= time_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[slot_reg]  <= key_reg;
            time_mem[slot_reg] <= time_reg;
        end
    end

    assign req_acc    = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign key_hit    = (rd_key_reg == key_reg);
    assign scan_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_count_reg);
    assign table_full = (fill_count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        pre_pass   = 1'b0;
        pre_status = ST_OK;
        if (!enabled_reg)
            pre_status = ST_DISABLED;
        else if (!key_ok(req.game_key, req.key_length))
            pre_status = ST_BAD_KEY;
        else if (req.command == CMD_RECORD &&
                 (req.play_time < min_time_reg || req.play_time > max_time_reg))
            pre_status = ST_BAD_TIME;
        else if (req.command == CMD_RECORD && gen_reg == GEN_MAX)
            pre_status = ST_GEN_FULL;
        else
            pre_pass = 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    if (!pre_pass)
                        state_next = S_DONE;
                    else if (fill_count_reg == '0)
                        state_next = (req.command == CMD_RECORD) ? S_WRITE : S_DONE;
                    else
                        state_next = S_READ;
                end
            end
            S_READ:     state_next = S_COMP;
            S_COMP:
            begin
                if (key_hit || scan_last)
                begin
                    if (cmd_reg == CMD_LOOKUP)
                        state_next = S_DONE;
                    else if (!key_hit && table_full)
                        state_next = S_OLD_READ;
                    else
                        state_next = S_WRITE;
                end
                else
                    state_next = S_READ;
            end
            S_OLD_READ: state_next = S_OLD_COMP;
            S_OLD_COMP:
            begin
                if (idx_reg == IDX_W'(CAPACITY - 1))
                    state_next = S_WRITE;
                else
                    state_next = S_OLD_READ;
            end
            S_WRITE:    state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready = (state_reg == S_IDLE);
        mem_we    = (state_reg == S_WRITE);
    end

    // datapath
    always_comb
    begin
        idx_next        = idx_reg;
        slot_next       = slot_reg;
        best_next       = best_reg;
        append_next     = append_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        time_next       = time_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        fill_count_next = fill_count_reg;
        gen_next        = gen_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    cmd_next    = req.command;
                    key_next    = req.game_key;
                    time_next   = req.play_time;
                    idx_next    = '0;
                    slot_next   = '0;
                    found_next  = '0;
                    append_next = (fill_count_reg == '0);
                    if (!pre_pass)
                        status_next = pre_status;
                    else if (fill_count_reg == '0 && req.command == CMD_LOOKUP)
                        status_next = ST_NOT_FOUND;
                    else
                        status_next = ST_OK;
                end
            end
            S_COMP:
            begin
                if (key_hit)
                begin
                    slot_next = idx_reg;
                    if (cmd_reg == CMD_LOOKUP)
                        found_next = rd_time_reg;
                end
                else if (scan_last)
                begin
                    if (cmd_reg == CMD_LOOKUP)
                        status_next = ST_NOT_FOUND;
                    else if (table_full)
                        idx_next = '0;
                    else
                    begin
                        slot_next   = IDX_W'(fill_count_reg);
                        append_next = 1'b1;
                    end
                end
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            S_OLD_COMP:
            begin
                if (idx_reg == '0 || rd_time_reg < best_reg)
                begin
                    best_next = rd_time_reg;
                    slot_next = idx_reg;
                end
                if (idx_reg != IDX_W'(CAPACITY - 1))
                    idx_next = idx_reg + IDX_W'(1);
            end
            S_WRITE:
            begin
                gen_next = gen_reg + GEN_W'(1);
                if (append_reg)
                    fill_count_next = fill_count_reg + CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_count_reg <= '0;
            gen_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            gen_reg        <= gen_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        best_reg   <= best_next;
        append_reg <= append_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        time_reg   <= time_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_found_reg  <= found_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= ENTRY_W'(fill_count_reg);
            out_gen_reg    <= gen_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.found_time     = out_found_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.entry_count    = out_count_reg;
    assign rsp.generation_out = out_gen_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_gen_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_WRITE |=> $stable(gen_reg) && $stable(fill_count_reg))
        else $error("table state changed outside a write");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> state_reg != S_IDLE)
        else $error("item accepted but no work started");

    a_write_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |-> status_reg == ST_OK && cmd_reg == CMD_RECORD)
        else $error("write for a rejected or lookup item");

endmodule
